// ===== rtl/core/arim_pkg.sv =====
// ----------------------------------------------------------------------------
// arim_pkg: shared types and constants for the auto-ranging impedance meter
// Widths, register codes, range tables and sequencer states.
// ----------------------------------------------------------------------------
package arim_pkg;

	localparam int SAMPLE_W = 12;
	localparam int D_W      = SAMPLE_W + 1;
	localparam int CORR_W   = 16;
	localparam int RI_W     = 2;
	localparam int FI_W     = 3;
	localparam int EST_W    = 32;
	localparam int PER_W    = 13;
	localparam int WAV_W    = 9;

	// shared datapath widths
	localparam int ALU_W  = 76;  // cap numerator < 2^76
	localparam int DEN_W  = 62;  // cap denominator < 2^62
	localparam int REM_W  = 63;
	localparam int ROOT_W = 20;
	localparam int SQV_W  = 40;
	localparam int MCB_W  = 20;
	localparam int PRD_W  = 25;
	localparam int CNT_W  = 7;
	localparam int SQRT_FRAC = 8;

	localparam logic [RI_W-1:0] RI_MAX = 2'd3;
	localparam logic [FI_W-1:0] FI_MAX = 3'd5;

	localparam logic [1:0] REGIME_EST   = 2'd0;
	localparam logic [1:0] REGIME_UNDER = 2'd1;
	localparam logic [1:0] REGIME_OVER  = 2'd2;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] CFG_FULL_SCALE = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_UNDER_THR  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_OVER_THR   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_RES_CORR   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_CAP_CORR   = 3'd4;

	localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST = 12'd685;
	localparam logic [SAMPLE_W-1:0] UNDER_THR_RST  = 12'd137;
	localparam logic [SAMPLE_W-1:0] OVER_THR_RST   = 12'd548;
	localparam logic [CORR_W-1:0]   RES_CORR_RST   = 16'd812;
	localparam logic [CORR_W-1:0]   CAP_CORR_RST   = 16'd1222;

	localparam logic [ALU_W-1:0] K_PICO = 76'd1000000000000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_CHK,
		ST_SQRT,
		ST_MUL_DEN,
		ST_MUL_K,
		ST_MUL_NUM,
		ST_DIV,
		ST_OUT
	} arim_state_t;

	function automatic logic [16:0] res_ohms(input logic [RI_W-1:0] ri);
		case (ri)
			2'd0:    return 17'd3300;
			2'd1:    return 17'd10000;
			2'd2:    return 17'd33000;
			default: return 17'd100000;
		endcase
	endfunction

	function automatic logic [PER_W-1:0] timer_period(input logic [FI_W-1:0] fi);
		case (fi)
			3'd0:    return 13'd5555;
			3'd1:    return 13'd1111;
			3'd2:    return 13'd555;
			3'd3:    return 13'd555;
			default: return 13'd444;
		endcase
	endfunction

	function automatic logic [WAV_W-1:0] wave_samples(input logic [FI_W-1:0] fi);
		case (fi)
			3'd0, 3'd1, 3'd2: return 9'd360;
			3'd3:             return 9'd180;
			3'd4:             return 9'd90;
			default:          return 9'd45;
		endcase
	endfunction

	// 6283 * R * f, i.e. 2*pi scaled by 1000
	function automatic logic [41:0] den_const(input logic [RI_W-1:0] ri,
						  input logic [FI_W-1:0] fi);
		logic [41:0] r;
		logic [41:0] f;
		case (ri)
			2'd0:    r = 42'd3300;
			2'd1:    r = 42'd10000;
			2'd2:    r = 42'd33000;
			default: r = 42'd100000;
		endcase
		case (fi)
			3'd0:    f = 42'd6283 * 42'd50;
			3'd1:    f = 42'd6283 * 42'd250;
			3'd2:    f = 42'd6283 * 42'd500;
			3'd3:    f = 42'd6283 * 42'd1000;
			3'd4:    f = 42'd6283 * 42'd2500;
			default: f = 42'd6283 * 42'd5000;
		endcase
		case (ri)
			2'd0:    return f * 42'd3300;
			2'd1:    return f * 42'd10000;
			2'd2:    return f * 42'd33000;
			default: return (r == 42'd100000) ? f * 42'd100000 : f * 42'd100000;
		endcase
	endfunction

endpackage

// ===== rtl/core/auto_ranging_impedance_meter_top.sv =====
// ----------------------------------------------------------------------------
// auto_ranging_impedance_meter_top: one ranging step per input word
// Sorts a peak reading into a regime, steps the range, estimates R or C.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tdata holds
//    the 12-bit peak reading, s_tuser selects capacitance (1) or resistance.
//  - One result word per input leaves on m_tvalid/m_tready/m_tdata/m_tuser.
//  - Range stepping is settled at the accept edge; the estimate is built by
//    one shared 76-bit add/subtract unit under a small sequencer:
//    shift-add multiplies, a bit-per-cycle integer square root and a
//    restoring divider that produces one quotient bit per cycle.
//  - A word that is not established, or whose denominator check saturates,
//    goes to the output without the multiply and divide steps. A resistance
//    estimate runs two shift-add multiplies and then the divide; a
//    capacitance estimate runs the root, three multiplies and then the
//    divide. The divider dominates.
//  - s_tready is high only while the sequencer is idle; one word at a time.
//  - The result sits in an output register; a new word is taken while it
//    waits, and the sequencer holds its next result until m_tready frees it.
//  - Reset (arst_n low) returns both range indices to 0 and all
//    configuration registers to their defaults, and drops m_tvalid.
//  - Configuration: cfg_we writes cfg_wdata to register cfg_addr; write only
//    while idle.
// ----------------------------------------------------------------------------
module auto_ranging_impedance_meter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] peak_sample
	input  logic        s_tuser,   // [0] measure_capacitance
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] regime, [2] out_of_range, [4:3] res_index, [7:5] freq_index,
	// [20:8] timer_period, [29:21] wave_samples, [30] estimate_valid,
	// [62:31] estimate_value, [63] zero
	output logic [63:0] m_tdata,
	output logic        m_tuser,   // [0] estimate_is_capacitance
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	localparam int AW = arim_pkg::ALU_W;

	arim_pkg::arim_state_t state_q, state_d;

	// configuration
	logic [arim_pkg::SAMPLE_W-1:0] fs_q, under_q, over_q;
	logic [arim_pkg::CORR_W-1:0]   rcorr_q, ccorr_q;

	// range state (new indices after each accept)
	logic [arim_pkg::RI_W-1:0] ri_q;
	logic [arim_pkg::FI_W-1:0] freq_q;

	// per-word hold
	logic [arim_pkg::RI_W-1:0]  old_ri_q;
	logic [arim_pkg::FI_W-1:0]  old_fi_q;
	logic [arim_pkg::D_W-1:0]   d_q;
	logic                       cap_q;
	logic [1:0]                 regime_q;
	logic                       oor_q;
	logic [arim_pkg::EST_W-1:0] est_q;

	// shared datapath
	logic [AW-1:0]                   acc_q, mca_q;
	logic [arim_pkg::MCB_W-1:0]      mcb_q;
	logic [arim_pkg::REM_W-1:0]      rem_q;
	logic [arim_pkg::DEN_W-1:0]      den_q;
	logic [arim_pkg::ROOT_W-1:0]     root_q;
	logic [arim_pkg::SQV_W-1:0]      sqv_q;
	logic [arim_pkg::PRD_W-1:0]      pa_q, pb_q;
	logic [arim_pkg::CNT_W-1:0]      cnt_q;

	// output register
	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic        m_tuser_q;

	// ranging decision, combinational on the incoming word
	logic [arim_pkg::SAMPLE_W-1:0] v_in;
	logic                          cap_in;
	logic [arim_pkg::FI_W-1:0]     fi_c;
	logic [1:0]                    regime_n;
	logic [arim_pkg::RI_W-1:0]     nr;
	logic [arim_pkg::FI_W-1:0]     nf;
	logic                          oor_n;
	logic                          accept;
	logic                          out_load;

	assign v_in   = s_tdata[arim_pkg::SAMPLE_W-1:0];
	assign cap_in = s_tuser;
	assign fi_c   = (freq_q > arim_pkg::FI_MAX) ? arim_pkg::FI_MAX : freq_q;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		if (v_in < under_q)
			regime_n = arim_pkg::REGIME_UNDER;
		else if (v_in > over_q)
			regime_n = arim_pkg::REGIME_OVER;
		else
			regime_n = arim_pkg::REGIME_EST;

		nr    = ri_q;
		nf    = fi_c;
		oor_n = 1'b0;
		if (!cap_in) begin
			nf = arim_pkg::FI_MAX;
			if (regime_n == arim_pkg::REGIME_OVER) begin
				if (ri_q < arim_pkg::RI_MAX) nr = ri_q + 2'd1;
				else oor_n = 1'b1;
			end else if (regime_n == arim_pkg::REGIME_UNDER) begin
				if (ri_q > 2'd0) nr = ri_q - 2'd1;
				else oor_n = 1'b1;
			end
		end else begin
			if (regime_n == arim_pkg::REGIME_OVER) begin
				if (ri_q < arim_pkg::RI_MAX) nr = ri_q + 2'd1;
				else if (fi_c < arim_pkg::FI_MAX) begin
					nf = fi_c + 3'd1;
					nr = 2'd0;
				end else oor_n = 1'b1;
			end else if (regime_n == arim_pkg::REGIME_UNDER) begin
				if (ri_q > 2'd0) nr = ri_q - 2'd1;
				else if (fi_c > 3'd0) begin
					nf = fi_c - 3'd1;
					nr = arim_pkg::RI_MAX;
				end else oor_n = 1'b1;
			end
		end
	end

	// shared add/subtract unit
	logic [AW-1:0] alu_a, alu_b;
	logic          alu_sub;
	logic [AW:0]   alu_sum;
	logic          alu_ge;
	logic [22:0]   sq_t;
	logic [arim_pkg::REM_W-1:0] div_t;
	logic [AW-1:0] acc_nxt;
	logic [arim_pkg::ROOT_W-1:0] root_nxt;
	logic [arim_pkg::PRD_W-1:0]  diff;
	logic          cnt_done;

	assign sq_t  = {rem_q[20:0], sqv_q[arim_pkg::SQV_W-1 -: 2]};
	assign div_t = {rem_q[arim_pkg::REM_W-2:0], acc_q[AW-1]};

	always_comb begin
		case (state_q)
			arim_pkg::ST_SQRT: begin
				alu_a   = AW'(sq_t);
				alu_b   = AW'({root_q, 2'b01});
				alu_sub = 1'b1;
			end
			arim_pkg::ST_DIV: begin
				alu_a   = AW'(div_t);
				alu_b   = AW'(den_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = acc_q;
				alu_b   = mca_q;
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_sum  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
	assign alu_ge   = alu_sum[AW];
	assign acc_nxt  = mcb_q[0] ? alu_sum[AW-1:0] : acc_q;
	assign root_nxt = {root_q[arim_pkg::ROOT_W-2:0], alu_ge};
	assign diff     = pa_q - pb_q;
	assign cnt_done = (cnt_q == '0);
	assign out_load = (state_q == arim_pkg::ST_OUT) && (!m_tvalid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= arim_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			arim_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = (regime_n == arim_pkg::REGIME_EST) ?
						  arim_pkg::ST_PREP : arim_pkg::ST_OUT;
			end
			arim_pkg::ST_PREP: state_d = arim_pkg::ST_CHK;
			arim_pkg::ST_CHK: begin
				if (pa_q <= pb_q) state_d = arim_pkg::ST_OUT;
				else if (cap_q) state_d = arim_pkg::ST_SQRT;
				else state_d = arim_pkg::ST_MUL_K;
			end
			arim_pkg::ST_SQRT:    if (cnt_done) state_d = arim_pkg::ST_MUL_DEN;
			arim_pkg::ST_MUL_DEN: if (cnt_done) state_d = arim_pkg::ST_MUL_K;
			arim_pkg::ST_MUL_K:   if (cnt_done) state_d = arim_pkg::ST_MUL_NUM;
			arim_pkg::ST_MUL_NUM: if (cnt_done) state_d = arim_pkg::ST_DIV;
			arim_pkg::ST_DIV:     if (cnt_done) state_d = arim_pkg::ST_OUT;
			arim_pkg::ST_OUT:     if (!m_tvalid_q || m_tready) state_d = arim_pkg::ST_IDLE;
			default:              state_d = arim_pkg::ST_IDLE;
		endcase
	end

	// configuration and range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q    <= arim_pkg::FULL_SCALE_RST;
			under_q <= arim_pkg::UNDER_THR_RST;
			over_q  <= arim_pkg::OVER_THR_RST;
			rcorr_q <= arim_pkg::RES_CORR_RST;
			ccorr_q <= arim_pkg::CAP_CORR_RST;
			ri_q    <= '0;
			freq_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					arim_pkg::CFG_FULL_SCALE: fs_q    <= cfg_wdata[arim_pkg::SAMPLE_W-1:0];
					arim_pkg::CFG_UNDER_THR:  under_q <= cfg_wdata[arim_pkg::SAMPLE_W-1:0];
					arim_pkg::CFG_OVER_THR:   over_q  <= cfg_wdata[arim_pkg::SAMPLE_W-1:0];
					arim_pkg::CFG_RES_CORR:   rcorr_q <= cfg_wdata;
					arim_pkg::CFG_CAP_CORR:   ccorr_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				ri_q   <= nr;
				freq_q <= nf;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			arim_pkg::ST_IDLE: begin
				if (accept) begin
					old_ri_q <= ri_q;
					old_fi_q <= fi_c;
					d_q      <= arim_pkg::D_W'(v_in) + 13'd1;
					cap_q    <= cap_in;
					regime_q <= regime_n;
					oor_q    <= oor_n;
					est_q    <= '0;
				end
			end
			arim_pkg::ST_PREP: begin
				if (cap_q) begin
					pa_q <= arim_pkg::PRD_W'(fs_q) * arim_pkg::PRD_W'(fs_q);
					pb_q <= arim_pkg::PRD_W'(d_q) * arim_pkg::PRD_W'(d_q);
				end else begin
					pa_q <= arim_pkg::PRD_W'(fs_q) * 25'd100;
					pb_q <= arim_pkg::PRD_W'(d_q) * 25'd99;
				end
			end
			arim_pkg::ST_CHK: begin
				acc_q <= '0;
				if (pa_q <= pb_q) begin
					// reading at or past full scale
					est_q <= cap_q ? '0 : '1;
				end else if (cap_q) begin
					sqv_q  <= arim_pkg::SQV_W'(diff) << (2 * arim_pkg::SQRT_FRAC);
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= arim_pkg::CNT_W'(arim_pkg::ROOT_W - 1);
				end else begin
					den_q <= (arim_pkg::DEN_W'(diff) << 3) + (arim_pkg::DEN_W'(diff) << 1);
					mca_q <= AW'(arim_pkg::res_ohms(old_ri_q));
					mcb_q <= arim_pkg::MCB_W'(rcorr_q);
					cnt_q <= arim_pkg::CNT_W'(arim_pkg::CORR_W - 1);
				end
			end
			arim_pkg::ST_SQRT: begin
				rem_q  <= alu_ge ? arim_pkg::REM_W'(alu_sum[22:0]) : arim_pkg::REM_W'(sq_t);
				root_q <= root_nxt;
				sqv_q  <= sqv_q << 2;
				cnt_q  <= cnt_q - 7'd1;
				if (cnt_done) begin
					mca_q <= AW'(arim_pkg::den_const(old_ri_q, old_fi_q));
					mcb_q <= arim_pkg::MCB_W'(d_q);
					acc_q <= '0;
					cnt_q <= arim_pkg::CNT_W'(arim_pkg::D_W - 1);
				end
			end
			arim_pkg::ST_MUL_DEN, arim_pkg::ST_MUL_K, arim_pkg::ST_MUL_NUM: begin
				acc_q <= acc_nxt;
				mca_q <= mca_q << 1;
				mcb_q <= mcb_q >> 1;
				cnt_q <= cnt_q - 7'd1;
				if (cnt_done) begin
					if (state_q == arim_pkg::ST_MUL_DEN) begin
						den_q <= arim_pkg::DEN_W'(acc_nxt) << arim_pkg::SQRT_FRAC;
						mca_q <= arim_pkg::K_PICO;
						mcb_q <= arim_pkg::MCB_W'(ccorr_q);
						acc_q <= '0;
						cnt_q <= arim_pkg::CNT_W'(arim_pkg::CORR_W - 1);
					end else if (state_q == arim_pkg::ST_MUL_K) begin
						mca_q <= acc_nxt;
						mcb_q <= cap_q ? root_q : arim_pkg::MCB_W'(d_q);
						acc_q <= '0;
						cnt_q <= cap_q ? arim_pkg::CNT_W'(arim_pkg::ROOT_W - 1) :
							arim_pkg::CNT_W'(arim_pkg::D_W - 1);
					end else begin
						rem_q <= '0;
						cnt_q <= arim_pkg::CNT_W'(AW - 1);
					end
				end
			end
			arim_pkg::ST_DIV: begin
				rem_q <= alu_ge ? alu_sum[arim_pkg::REM_W-1:0] : div_t;
				acc_q <= {acc_q[AW-2:0], alu_ge};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_done)
					est_q <= (|acc_q[AW-2:arim_pkg::EST_W-1]) ? '1 :
						 {acc_q[arim_pkg::EST_W-2:0], alu_ge};
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {1'b0, est_q, (regime_q == arim_pkg::REGIME_EST),
				      arim_pkg::wave_samples(freq_q), arim_pkg::timer_period(freq_q),
				      freq_q, ri_q, oor_q, regime_q};
			m_tuser_q <= cap_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// checks
	ap_freq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		freq_q <= arim_pkg::FI_MAX)
		else $error("frequency index beyond top range");

	ap_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != arim_pkg::ST_IDLE)
		else $error("sequencer idle after accept");

	ap_no_est_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[30] |-> m_tdata[62:31] == 32'd0)
		else $error("estimate given without established regime");

	// resistance mode still forces the top frequency when out of range
	ap_oor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && oor_n |=> ri_q == $past(ri_q) &&
			(!$past(cap_in) || freq_q == $past(fi_c)))
		else $error("range moved while out of range");

endmodule
